FILE: src/dtl_pkg.sv
package dtl_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int NKW           = 14;

    localparam logic [4:0] TYPE_IDENT  = 5'd0;
    localparam logic [4:0] TYPE_NUMBER = 5'd1;
    localparam logic [4:0] TYPE_STRING = 5'd2;
    localparam logic [4:0] TYPE_KW0    = 5'd3;
    localparam logic [4:0] TYPE_SYM0   = 5'd17;
    localparam logic [4:0] TYPE_EOF    = 5'd25;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_ESC_EOI  = 3'd1;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
    localparam logic [2:0] ERR_STR_EOI  = 3'd3;
    localparam logic [2:0] ERR_UNEXPECT = 3'd4;

    // one result word without its line number
    typedef struct packed {
        logic [4:0] token_type;
        logic       char_valid;
        logic [7:0] content_char;
        logic       token_done;
        logic [2:0] error_code;
    } t_res;

    // keyword text, character at position p of keyword k (blank past its end, 0 from position 10 on)
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
        logic [8*10-1:0] s;
        case (k)
            4'd0:    s = "template  ";
            4'd1:    s = "service   ";
            4'd2:    s = "stage     ";
            4'd3:    s = "use       ";
            4'd4:    s = "from      ";
            4'd5:    s = "run       ";
            4'd6:    s = "copy      ";
            4'd7:    s = "env       ";
            4'd8:    s = "expose    ";
            4'd9:    s = "cmd       ";
            4'd10:   s = "entrypoint";
            4'd11:   s = "workdir   ";
            4'd12:   s = "port      ";
            4'd13:   s = {"depends", "_on"};
            default: s = "          ";
        endcase
        if (p < 4'd10) begin
            kw_char = s[8*(9-p) +: 8];
        end else begin
            kw_char = 8'd0;
        end
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        case (k)
            4'd0:    kw_len = 4'd8;
            4'd1:    kw_len = 4'd7;
            4'd2:    kw_len = 4'd5;
            4'd3:    kw_len = 4'd3;
            4'd4:    kw_len = 4'd4;
            4'd5:    kw_len = 4'd3;
            4'd6:    kw_len = 4'd4;
            4'd7:    kw_len = 4'd3;
            4'd8:    kw_len = 4'd6;
            4'd9:    kw_len = 4'd3;
            4'd10:   kw_len = 4'd10;
            4'd11:   kw_len = 4'd7;
            4'd12:   kw_len = 4'd4;
            4'd13:   kw_len = 4'd10;
            default: kw_len = 4'd0;
        endcase
    endfunction

endpackage

FILE: src/dsl_token_lexer_core.sv
// Streaming lexer for a small build-description language.
// Input channel: push/full with i_opcode (0 byte, 1 end of input) and i_in_byte.
// Output channel: empty/pop; the oldest result word sits on the o_ ports while
// o_empty is low. A byte yields zero, one or two words.
// Throughput: one byte per cycle while the result queue has room for two words.
// A word enters the queue as its byte is accepted; older words are handed out first.
// The scanner state is a single register stage; the four-word queue decouples
// it from the reader. When the reader stalls the queue fills and full rises
// once fewer than two slots remain.
// Reset clears scanner state (line count one, normal mode) and empties the
// queue. After an error the block gives no more words until reset.
module dsl_token_lexer_core #(
    parameter int LINE_BITS = dtl_pkg::LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_opcode,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_token_type,
    output logic        o_char_valid,
    output logic [7:0]  o_content_char,
    output logic        o_token_done,
    output logic [15:0] o_line_number,
    output logic [2:0]  o_error_code
);

    logic          take, room2;
    logic [1:0]    cnt;
    dtl_pkg::t_res res0, res1, res_q;
    logic [15:0]   line0, line1;

    assign full = !room2;
    assign take = push && room2;

    dtl_front #(.LINE_BITS(LINE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_opcode(i_opcode), .i_in_byte(i_in_byte),
        .o_cnt(cnt), .o_res0(res0), .o_res1(res1),
        .o_line0(line0), .o_line1(line1)
    );

    dtl_queue #(.DEPTH(4)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_cnt(take ? cnt : 2'd0),
        .i_res0(res0), .i_res1(res1), .i_line0(line0), .i_line1(line1),
        .o_room2(room2), .i_pop(pop), .o_empty(empty),
        .o_res(res_q), .o_line(o_line_number)
    );

    assign o_token_type   = res_q.token_type;
    assign o_char_valid   = res_q.char_valid;
    assign o_content_char = res_q.content_char;
    assign o_token_done   = res_q.token_done;
    assign o_error_code   = res_q.error_code;

endmodule

FILE: src/dtl_front.sv
// Scanner: classifies each byte and builds up to two result words per byte.
module dtl_front #(
    parameter int LINE_BITS = dtl_pkg::LINE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic           i_opcode,
    input  logic [7:0]     i_in_byte,
    output logic [1:0]     o_cnt,
    output dtl_pkg::t_res  o_res0,
    output dtl_pkg::t_res  o_res1,
    output logic [15:0]    o_line0,
    output logic [15:0]    o_line1
);

    typedef enum logic [2:0] {
        M_NORMAL, M_COMMENT, M_IDENT, M_NUMBER, M_STRING, M_ESCAPE, M_HALT
    } t_mode;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    t_mode                 r_mode, n_mode;
    logic [LINE_BITS-1:0]  r_line, n_line;
    logic [13:0]           r_alive, n_alive;
    logic [3:0]            r_len, n_len;

    logic                  is_alpha, is_digit, is_idc;
    logic [13:0]           alive_upd;
    logic [4:0]            id_type;
    logic [3:0]            sym_idx;
    logic                  is_sym;
    logic [LINE_BITS-1:0]  line_inc;

    assign is_alpha = (i_in_byte >= 8'h61 && i_in_byte <= 8'h7a) ||
                      (i_in_byte >= 8'h41 && i_in_byte <= 8'h5a);
    assign is_digit = i_in_byte >= 8'h30 && i_in_byte <= 8'h39;
    assign is_idc   = is_alpha || is_digit || i_in_byte == 8'h5f;
    assign line_inc = (r_line == LINE_MAX) ? r_line : r_line + 1'b1;

    // match bits for the current byte against every keyword
    always_comb begin
        for (int k = 0; k < dtl_pkg::NKW; k++) begin
            alive_upd[k] = r_alive[k] && (r_len < dtl_pkg::kw_len(4'(k))) &&
                           (dtl_pkg::kw_char(4'(k), r_len) == i_in_byte);
        end
    end

    // final identifier type, first live keyword of matching length
    always_comb begin
        id_type = dtl_pkg::TYPE_IDENT;
        for (int k = dtl_pkg::NKW - 1; k >= 0; k--) begin
            if (r_alive[k] && dtl_pkg::kw_len(4'(k)) == r_len) begin
                id_type = dtl_pkg::TYPE_KW0 + 5'(k);
            end
        end
    end

    // symbol lookup
    always_comb begin
        is_sym  = 1'b1;
        case (i_in_byte)
            8'h7b:   sym_idx = 4'd0;
            8'h7d:   sym_idx = 4'd1;
            8'h28:   sym_idx = 4'd2;
            8'h29:   sym_idx = 4'd3;
            8'h5b:   sym_idx = 4'd4;
            8'h5d:   sym_idx = 4'd5;
            8'h2c:   sym_idx = 4'd6;
            8'h3d:   sym_idx = 4'd7;
            default: begin
                sym_idx = 4'd0;
                is_sym  = 1'b0;
            end
        endcase
    end

    // next state and result words
    always_comb begin
        dtl_pkg::t_res res [2];
        logic [1:0]    cnt;
        logic          btw;
        logic [15:0]   l_first;
        n_mode  = r_mode;
        n_line  = r_line;
        n_alive = r_alive;
        n_len   = r_len;
        cnt     = 2'd0;
        btw     = 1'b0;
        res[0]  = '0;
        res[1]  = '0;
        l_first = 16'(r_line);
        if (i_opcode) begin
            case (r_mode)
                M_HALT: ;
                M_STRING: begin
                    res[0].error_code = dtl_pkg::ERR_STR_EOI;
                    cnt = 2'd1;
                    n_mode = M_HALT;
                end
                M_ESCAPE: begin
                    res[0].error_code = dtl_pkg::ERR_ESC_EOI;
                    cnt = 2'd1;
                    n_mode = M_HALT;
                end
                default: begin
                    if (r_mode == M_IDENT || r_mode == M_NUMBER) begin
                        res[0].token_type = (r_mode == M_IDENT) ? id_type
                                                                : dtl_pkg::TYPE_NUMBER;
                        res[0].token_done = 1'b1;
                        cnt = 2'd1;
                    end
                    res[cnt[0]].token_type = dtl_pkg::TYPE_EOF;
                    res[cnt[0]].token_done = 1'b1;
                    cnt     = cnt + 2'd1;
                    n_mode  = M_NORMAL;
                    n_line  = LINE_BITS'(1);
                    n_alive = '1;
                    n_len   = '0;
                end
            endcase
        end else begin
            case (r_mode)
                M_HALT: ;
                M_COMMENT: begin
                    if (i_in_byte == 8'h0a) begin
                        n_mode = M_NORMAL;
                        n_line = line_inc;
                    end
                end
                M_IDENT: begin
                    if (is_idc) begin
                        n_alive = alive_upd;
                        n_len = (r_len == 4'd15) ? r_len : r_len + 4'd1;
                        res[0].char_valid = 1'b1;
                        res[0].content_char = i_in_byte;
                        cnt = 2'd1;
                    end else begin
                        res[0].token_type = id_type;
                        res[0].token_done = 1'b1;
                        cnt = 2'd1;
                        btw = 1'b1;
                    end
                end
                M_NUMBER: begin
                    res[0].char_valid = is_digit;
                    res[0].content_char = is_digit ? i_in_byte : 8'd0;
                    res[0].token_type = is_digit ? dtl_pkg::TYPE_IDENT
                                                 : dtl_pkg::TYPE_NUMBER;
                    res[0].token_done = !is_digit;
                    cnt = 2'd1;
                    btw = !is_digit;
                end
                M_STRING: begin
                    if (i_in_byte == 8'h22) begin
                        res[0].token_type = dtl_pkg::TYPE_STRING;
                        res[0].token_done = 1'b1;
                        cnt = 2'd1;
                        n_mode = M_NORMAL;
                    end else if (i_in_byte == 8'h5c) begin
                        n_mode = M_ESCAPE;
                    end else begin
                        if (i_in_byte == 8'h0a) begin
                            n_line = line_inc;
                            l_first = 16'(line_inc);
                        end
                        res[0].char_valid = 1'b1;
                        res[0].content_char = i_in_byte;
                        cnt = 2'd1;
                    end
                end
                M_ESCAPE: begin
                    cnt = 2'd1;
                    res[0].char_valid = 1'b1;
                    n_mode = M_STRING;
                    case (i_in_byte)
                        8'h6e:   res[0].content_char = 8'h0a;
                        8'h74:   res[0].content_char = 8'h09;
                        8'h22:   res[0].content_char = 8'h22;
                        8'h5c:   res[0].content_char = 8'h5c;
                        default: begin
                            res[0] = '0;
                            res[0].error_code = dtl_pkg::ERR_BAD_ESC;
                            n_mode = M_HALT;
                        end
                    endcase
                end
                default: btw = 1'b1;
            endcase
            // byte between tokens, possibly after a finished token
            if (btw) begin
                n_mode = M_NORMAL;
                if (i_in_byte == 8'h20 || i_in_byte == 8'h09 || i_in_byte == 8'h0d) begin
                end else if (i_in_byte == 8'h0a) begin
                    n_line = line_inc;
                end else if (i_in_byte == 8'h23) begin
                    n_mode = M_COMMENT;
                end else if (is_alpha || i_in_byte == 8'h5f) begin
                    n_mode = M_IDENT;
                    for (int k = 0; k < dtl_pkg::NKW; k++) begin
                        n_alive[k] = dtl_pkg::kw_char(4'(k), 4'd0) == i_in_byte;
                    end
                    n_len = 4'd1;
                    res[cnt[0]].char_valid = 1'b1;
                    res[cnt[0]].content_char = i_in_byte;
                    cnt = cnt + 2'd1;
                end else if (is_digit) begin
                    n_mode = M_NUMBER;
                    res[cnt[0]].char_valid = 1'b1;
                    res[cnt[0]].content_char = i_in_byte;
                    cnt = cnt + 2'd1;
                end else if (i_in_byte == 8'h22) begin
                    n_mode = M_STRING;
                end else if (is_sym) begin
                    res[cnt[0]].token_type = dtl_pkg::TYPE_SYM0 + 5'(sym_idx);
                    res[cnt[0]].char_valid = 1'b1;
                    res[cnt[0]].content_char = i_in_byte;
                    res[cnt[0]].token_done = 1'b1;
                    cnt = cnt + 2'd1;
                end else begin
                    res[cnt[0]].error_code = dtl_pkg::ERR_UNEXPECT;
                    cnt = cnt + 2'd1;
                    n_mode = M_HALT;
                end
            end
        end
        o_cnt   = cnt;
        o_res0  = res[0];
        o_res1  = res[1];
        o_line0 = l_first;
        o_line1 = 16'(r_line);
    end

    // hold scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_line  <= LINE_BITS'(1);
            r_alive <= '1;
            r_len   <= '0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_alive <= n_alive;
            r_len   <= n_len;
        end
    end

endmodule

FILE: src/dtl_queue.sv
// Result queue: takes up to two words per cycle, hands out one.
module dtl_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_wr_cnt,
    input  dtl_pkg::t_res  i_res0,
    input  dtl_pkg::t_res  i_res1,
    input  logic [15:0]    i_line0,
    input  logic [15:0]    i_line1,
    output logic           o_room2,
    input  logic           i_pop,
    output logic           o_empty,
    output dtl_pkg::t_res  o_res,
    output logic [15:0]    o_line
);

    localparam int AW = $clog2(DEPTH);

    dtl_pkg::t_res  r_res  [DEPTH];
    logic [15:0]    r_line [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           pop_ok;

    assign o_empty = r_cnt == '0;
    assign pop_ok  = i_pop && !o_empty;
    assign o_room2 = r_cnt <= (AW+1)'(DEPTH - 2);
    assign o_res   = r_res[r_rp];
    assign o_line  = r_line[r_rp];

    // write words in order
    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_res[r_wp]  <= i_res0;
            r_line[r_wp] <= i_line0;
        end
        if (i_wr_cnt == 2'd2) begin
            r_res[AW'(r_wp + 1'b1)]  <= i_res1;
            r_line[AW'(r_wp + 1'b1)] <= i_line1;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(i_wr_cnt);
            r_rp  <= r_rp + AW'(pop_ok);
            r_cnt <= r_cnt + (AW+1)'(i_wr_cnt) - (AW+1)'(pop_ok);
        end
    end

endmodule

FILE: src/dtl_checker.sv
module dtl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_char_valid,
    input logic [7:0]  o_content_char,
    input logic        o_token_done,
    input logic [2:0]  o_error_code
);

    // reset leaves the result side empty
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("not empty after reset");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_content_char)))
        else $error("word changed under stall");

    // an error word carries no content and no done mark
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code != 3'd0) |-> (!o_char_valid && !o_token_done))
        else $error("error word with payload");

    // code range
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_error_code <= 3'd4)
        else $error("bad error code");

endmodule

bind dsl_token_lexer_core dtl_checker u_chk (.*);
